/* rtl/vnma_pkg.sv */
// Package: shared types, constants and arithmetic steps for the velocity/note mod amount block.
package vnma_pkg;

    localparam int CODE_W  = 8;
    localparam int VEL_W   = 7;
    localparam int NOTE_W  = 7;
    localparam int FRAC_W  = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;
    localparam int LANES   = 2;
    localparam int PIPE_DEPTH = 12;

    // register codes within a lane (index bits 1:0), lane in index bit 2
    localparam logic [1:0] REG_TARGET = 2'd0;
    localparam logic [1:0] REG_AMOUNT = 2'd1;
    localparam logic [1:0] REG_THRESH = 2'd2;
    localparam logic [1:0] REG_MODE   = 2'd3;

    // gate source codes, mode bits 2:1
    localparam logic [1:0] SRC_VEL_UP  = 2'd0;
    localparam logic [1:0] SRC_VEL_DN  = 2'd1;
    localparam logic [1:0] SRC_NOTE_UP = 2'd2;
    localparam logic [1:0] SRC_NOTE_DN = 2'd3;

    localparam logic [7:0] VEL_LO  = 8'd0;
    localparam logic [7:0] VEL_HI  = 8'd127;
    localparam logic [7:0] NOTE_LO = 8'd24;
    localparam logic [7:0] NOTE_HI = 8'd108;

    localparam logic [CODE_W-1:0] CODE_POW_MIN = 8'd5;

    localparam logic [16:0] SCALE_ONE  = 17'h10000;
    localparam logic [32:0] POW_ROUND  = 33'd32768;
    localparam logic [26:0] DIV40_BIAS = 27'd20;
    // ceil(2^24 / 5)
    localparam logic [21:0] RECIP_5    = 22'd3355444;
    localparam logic signed [FRAC_W-1:0] FRAC_MAX = 16'sd16384;
    localparam logic [19:0] FRAC_MAX_MAG = 20'd16384;

    localparam int DIV_STEPS  = 8;
    localparam int SQRT_STEPS = 4;

    typedef struct packed {
        logic              cnt;
        logic              full;
        logic signed [7:0] amount;
        logic [7:0]        span;
        logic [7:0]        rem;
        logic [15:0]       num;
        logic [15:0]       quo;
    } div_t;

    typedef struct packed {
        logic              cnt;
        logic              full;
        logic signed [7:0] amount;
        logic [15:0]       lin;
        logic [15:0]       rad;
        logic [16:0]       rem;
        logic [15:0]       root;
    } sqrt_t;

    // restoring division, one quotient bit per step
    function automatic div_t div_step(div_t d);
        div_t       r;
        logic [8:0] wide;
        r = d;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            wide  = {r.rem, r.num[15]};
            r.num = {r.num[14:0], 1'b0};
            if (wide >= {1'b0, r.span})
            begin
                r.rem = 8'(wide - {1'b0, r.span});
                r.quo = {r.quo[14:0], 1'b1};
            end
            else
            begin
                r.rem = wide[7:0];
                r.quo = {r.quo[14:0], 1'b0};
            end
        end
        return r;
    endfunction

    // digit-by-digit square root, one root bit per step
    function automatic sqrt_t sqrt_step(sqrt_t s);
        sqrt_t       r;
        logic [18:0] cur;
        logic [18:0] trial;
        r = s;
        for (int i = 0; i < SQRT_STEPS; i++)
        begin
            cur   = {r.rem, r.rad[15:14]};
            trial = {1'b0, r.root, 2'b01};
            r.rad = {r.rad[13:0], 2'b00};
            if (cur >= trial)
            begin
                r.rem  = 17'(cur - trial);
                r.root = {r.root[14:0], 1'b1};
            end
            else
            begin
                r.rem  = cur[16:0];
                r.root = {r.root[14:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

/* rtl/vnma_if.sv */
// Interfaces: request and result channels of the velocity/note mod amount block.
interface vnma_req_if;
    import vnma_pkg::*;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] param_code;
    logic [VEL_W-1:0]  velocity;
    logic [NOTE_W-1:0] note;

    modport source (output valid, output param_code, output velocity, output note,
                    input ready);
    modport sink   (input valid, input param_code, input velocity, input note,
                    output ready);
endinterface

interface vnma_rsp_if;
    import vnma_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [FRAC_W-1:0] fraction;

    modport source (output valid, output fraction, input ready);
    modport sink   (input valid, input fraction, output ready);
endinterface

/* rtl/velocity_note_mod_amount.sv */
// Top level: two-lane velocity/note modulation fraction, Q2.14, deep pipeline.
//
//   channel  | dir | payload                           | handshake
//   ---------+-----+-----------------------------------+-------------------
//   req      | in  | param_code[8] velocity[7] note[7] | valid/ready
//   rsp      | out | fraction[16] signed Q2.14         | valid/ready
//   cfg      | in  | cfg_index[4] cfg_data[8]          | cfg_we, no wait
//
// One request per cycle while the result channel does not stall the pipeline.
// Stages: lane decode, two 8-bit divider stages, four 4-bit root stages,
// power multiply, lane products, sum and /8, reciprocal multiply for /5, saturate.
// rst_n clears valid bits and config registers; payload registers are not reset.
// Each stage holds when its successor is full and stalled; bubbles still fill.
module velocity_note_mod_amount
(
    input  logic                              clk,
    input  logic                              rst_n,
    vnma_req_if.sink                          req,
    vnma_rsp_if.source                        rsp,
    input  logic                              cfg_we,
    input  logic [vnma_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vnma_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import vnma_pkg::*;

    localparam int NST = PIPE_DEPTH;

    logic [7:0]        tgt_reg  [LANES];
    logic signed [7:0] amt_reg  [LANES];
    logic [7:0]        thr_reg  [LANES];
    logic [2:0]        mode_reg [LANES];

    logic [NST-1:0] v_reg;
    logic [NST-1:0] v_next;
    logic [NST-1:0] en;
    logic [NST-1:0] hi_reg;

    div_t  div_reg [3][LANES];
    div_t  dec_div [LANES];
    div_t  div_nx1 [LANES];
    div_t  div_nx2 [LANES];
    sqrt_t sq_reg  [4][LANES];
    sqrt_t sq_nx   [4][LANES];

    logic              sc_cnt_reg [LANES];
    logic signed [7:0] sc_amt_reg [LANES];
    logic [16:0]       sc_reg     [LANES];
    logic [16:0]       sc_next    [LANES];

    logic signed [25:0] prod_reg  [LANES];
    logic signed [25:0] prod_next [LANES];

    logic [21:0] y_reg;
    logic [21:0] y_next;
    logic        neg_reg;
    logic        neg_next;
    logic [19:0] qm_reg;
    logic [19:0] qm_next;
    logic        neg2_reg;
    logic signed [FRAC_W-1:0] frac_reg;
    logic signed [FRAC_W-1:0] frac_next;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                tgt_reg[k]  <= '0;
                amt_reg[k]  <= '0;
                thr_reg[k]  <= '0;
                mode_reg[k] <= '0;
            end
        end
        else if (cfg_we && !cfg_index[3])
        begin
            unique case (cfg_index[1:0])
                REG_TARGET: tgt_reg[cfg_index[2]]  <= cfg_data;
                REG_AMOUNT: amt_reg[cfg_index[2]]  <= $signed(cfg_data);
                REG_THRESH: thr_reg[cfg_index[2]]  <= cfg_data;
                REG_MODE:   mode_reg[cfg_index[2]] <= cfg_data[2:0];
            endcase
        end
    end

    // stall chain
    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || rsp.ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next = v_reg;
        if (en[0])
        begin
            v_next[0] = req.valid;
        end
        for (int i = 1; i < NST; i++)
        begin
            if (en[i])
            begin
                v_next[i] = v_reg[i-1];
            end
        end
    end

    assign req.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // lane decode
    always_comb
    begin
        logic [1:0]        sel;
        logic              note_dom;
        logic              above;
        logic [7:0]        src;
        logic [7:0]        thr;
        logic [7:0]        hi;
        logic [7:0]        lo;
        logic              gated;
        logic signed [9:0] span;
        logic [7:0]        gap;
        logic              span_pos;
        for (int k = 0; k < LANES; k++)
        begin
            sel      = mode_reg[k][2:1];
            note_dom = (sel == SRC_NOTE_UP) || (sel == SRC_NOTE_DN);
            above    = (sel == SRC_VEL_UP) || (sel == SRC_NOTE_UP);
            src      = note_dom ? {1'b0, req.note} : {1'b0, req.velocity};
            thr      = thr_reg[k];
            hi       = note_dom ? NOTE_HI : VEL_HI;
            lo       = note_dom ? NOTE_LO : VEL_LO;
            gated    = above ? (src < thr) : (src > thr);
            span     = $signed(above ? ({2'b00, hi} - {2'b00, thr})
                                     : ({2'b00, thr} - {2'b00, lo}));
            gap      = above ? 8'(src - thr) : 8'(thr - src);
            span_pos = !span[9] && (span != '0);

            dec_div[k].cnt    = (tgt_reg[k] == req.param_code) && (amt_reg[k] != '0)
                                && !gated;
            dec_div[k].full   = mode_reg[k][0] || !span_pos || (gap >= span[7:0]);
            dec_div[k].amount = amt_reg[k];
            dec_div[k].span   = span[7:0];
            dec_div[k].rem    = gap;
            dec_div[k].num    = {9'd0, span[7:1]};
            dec_div[k].quo    = '0;
        end
    end

    // divider and root stages
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            div_nx1[k] = div_step(div_reg[0][k]);
            div_nx2[k] = div_step(div_reg[1][k]);

            sq_nx[0][k].cnt    = div_reg[2][k].cnt;
            sq_nx[0][k].full   = div_reg[2][k].full;
            sq_nx[0][k].amount = div_reg[2][k].amount;
            sq_nx[0][k].lin    = div_reg[2][k].quo;
            sq_nx[0][k].rad    = div_reg[2][k].quo;
            sq_nx[0][k].rem    = '0;
            sq_nx[0][k].root   = '0;
            sq_nx[0][k]        = sqrt_step(sq_nx[0][k]);
            for (int j = 1; j < 4; j++)
            begin
                sq_nx[j][k] = sqrt_step(sq_reg[j-1][k]);
            end
        end
    end

    // power knee and scale select
    always_comb
    begin
        logic [31:0] pm;
        logic [32:0] rnd;
        for (int k = 0; k < LANES; k++)
        begin
            pm  = sq_reg[3][k].lin * sq_reg[3][k].root;
            rnd = {1'b0, pm} + POW_ROUND;
            if (sq_reg[3][k].full)
            begin
                sc_next[k] = SCALE_ONE;
            end
            else if (hi_reg[6])
            begin
                sc_next[k] = {1'b0, rnd[31:16]};
            end
            else
            begin
                sc_next[k] = {1'b0, sq_reg[3][k].lin};
            end
        end
    end

    // lane products
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            prod_next[k] = sc_cnt_reg[k] ? (sc_amt_reg[k] * $signed({1'b0, sc_reg[k]}))
                                         : 26'sd0;
        end
    end

    // sum, magnitude, rounding bias and divide by 8
    always_comb
    begin
        logic signed [26:0] sum;
        logic [26:0]        mag;
        sum      = 27'(prod_reg[0]) + 27'(prod_reg[1]);
        neg_next = sum[26];
        mag      = neg_next ? 27'(-sum) : 27'(sum);
        mag      = mag + DIV40_BIAS;
        y_next   = mag[24:3];
    end

    // divide by 5 through reciprocal
    always_comb
    begin
        logic [43:0] pr;
        pr      = y_reg * RECIP_5;
        qm_next = pr[43:24];
    end

    // saturate per target class
    always_comb
    begin
        logic [19:0] lim;
        lim = (qm_reg > FRAC_MAX_MAG) ? FRAC_MAX_MAG : qm_reg;
        if (!neg2_reg)
        begin
            frac_next = $signed(lim[15:0]);
        end
        else if (hi_reg[10])
        begin
            frac_next = '0;
        end
        else
        begin
            frac_next = -$signed(lim[15:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            hi_reg[0] <= req.param_code >= CODE_POW_MIN;
            div_reg[0] <= dec_div;
        end
        for (int i = 1; i < NST; i++)
        begin
            if (en[i])
            begin
                hi_reg[i] <= hi_reg[i-1];
            end
        end
        if (en[1])
        begin
            div_reg[1] <= div_nx1;
        end
        if (en[2])
        begin
            div_reg[2] <= div_nx2;
        end
        for (int j = 0; j < 4; j++)
        begin
            if (en[3+j])
            begin
                sq_reg[j] <= sq_nx[j];
            end
        end
        if (en[7])
        begin
            for (int k = 0; k < LANES; k++)
            begin
                sc_cnt_reg[k] <= sq_reg[3][k].cnt;
                sc_amt_reg[k] <= sq_reg[3][k].amount;
            end
            sc_reg <= sc_next;
        end
        if (en[8])
        begin
            prod_reg <= prod_next;
        end
        if (en[9])
        begin
            y_reg   <= y_next;
            neg_reg <= neg_next;
        end
        if (en[10])
        begin
            qm_reg   <= qm_next;
            neg2_reg <= neg_reg;
        end
        if (en[11])
        begin
            frac_reg <= frac_next;
        end
    end

    assign rsp.valid    = v_reg[NST-1];
    assign rsp.fraction = frac_reg;

endmodule

/* rtl/vnma_checker.sv */
// Checker: port-level assertions for the velocity/note mod amount block, and its bind.
module vnma_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    input  logic                              req_ready,
    input  logic                              rsp_valid,
    input  logic                              rsp_ready,
    input  logic signed [vnma_pkg::FRAC_W-1:0] rsp_fraction
);
    import vnma_pkg::*;

    logic [4:0] cnt_reg;
    logic [4:0] cnt_next;

    // requests accepted and not yet delivered
    always_comb
    begin
        cnt_next = cnt_reg + 5'(req_valid && req_ready) - 5'(rsp_valid && rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fraction))
        else $error("result changed while stalled");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_fraction >= -FRAC_MAX) && (rsp_fraction <= FRAC_MAX))
        else $error("fraction out of range");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> cnt_reg != '0)
        else $error("result without a request");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == '0 |-> req_ready)
        else $error("empty pipeline refuses a request");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 5'(PIPE_DEPTH))
        else $error("more requests in flight than stages");

endmodule

bind velocity_note_mod_amount vnma_checker u_vnma_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_fraction (rsp.fraction)
);

/* verif/testbench.sv */
// Testbench for velocity_note_mod_amount: a directed table, then random requests with a predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import vnma_pkg::*;

    localparam logic [3:0] A_TARGET = {2'b00, REG_TARGET};
    localparam logic [3:0] A_AMOUNT = {2'b00, REG_AMOUNT};
    localparam logic [3:0] A_THRESH = {2'b00, REG_THRESH};
    localparam logic [3:0] A_MODE   = {2'b00, REG_MODE};
    localparam logic [3:0] B_TARGET = {2'b01, REG_TARGET};
    localparam logic [3:0] B_AMOUNT = {2'b01, REG_AMOUNT};
    localparam logic [3:0] B_THRESH = {2'b01, REG_THRESH};
    localparam logic [3:0] B_MODE   = {2'b01, REG_MODE};
    localparam logic [3:0] IDX_UNMAPPED = 4'd8;

    localparam int UNITY      = 65536;
    localparam int FULL_SCALE = 16384;
    localparam int BLOCKS     = 16;
    localparam int BLOCK_LEN  = 72;

    typedef enum logic {ROW_WRITE, ROW_QUERY} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [3:0]  idx;
        logic [7:0]  data;
        logic [7:0]  code;
        logic [6:0]  vel;
        logic [6:0]  note;
        bit          typed;
        int          fraction;
    } stim_row_t;

    typedef struct {
        logic [7:0]        target;
        logic signed [7:0] amount;
        logic [7:0]        threshold;
        logic [2:0]        mode;
    } lane_cfg_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [3:0] cfg_index;
    logic [7:0] cfg_data;

    vnma_req_if req();
    vnma_rsp_if rsp();

    lane_cfg_t          lanes [LANES];
    logic signed [15:0] fraction_due [$];
    stim_row_t          script [$];
    int                 mismatches = 0;
    int                 send_idle  = 0;
    int                 stall_pct  = 0;

    velocity_note_mod_amount uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = 65536;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= v)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    // -1 when the lane is gated out, else the Q16 scale
    function automatic longint lane_scale(lane_cfg_t c, logic [7:0] code, logic [6:0] vel,
                                          logic [6:0] note);
        logic [1:0] sel;
        bit         note_dom;
        bit         above;
        int         src;
        int         thr;
        int         top;
        int         bottom;
        int         span;
        int         gap;
        longint     lin;
        sel      = c.mode[2:1];
        note_dom = (sel == SRC_NOTE_UP) || (sel == SRC_NOTE_DN);
        above    = (sel == SRC_VEL_UP) || (sel == SRC_NOTE_UP);
        src      = note_dom ? int'(note) : int'(vel);
        thr      = int'(c.threshold);
        top      = note_dom ? int'(NOTE_HI) : int'(VEL_HI);
        bottom   = note_dom ? int'(NOTE_LO) : int'(VEL_LO);
        if (above ? (src < thr) : (src > thr))
            return -1;
        if (c.mode[0])
            return UNITY;
        span = above ? top - thr : thr - bottom;
        gap  = above ? src - thr : thr - src;
        if (span <= 0 || gap >= span)
            lin = UNITY;
        else
            lin = (longint'(gap) * UNITY + span / 2) / span;
        if (code >= CODE_POW_MIN)
            lin = longint'((lin * root_floor(lin << 16) + 32768) >> 16);
        return lin;
    endfunction

    function automatic logic signed [15:0] predict_fraction(logic [7:0] code, logic [6:0] vel,
                                                            logic [6:0] note);
        longint sum;
        longint s;
        longint mag;
        sum = 0;
        for (int k = 0; k < LANES; k++)
        begin
            if (lanes[k].target != code || lanes[k].amount == 0)
                continue;
            s = lane_scale(lanes[k], code, vel, note);
            if (s < 0)
                continue;
            sum += longint'(lanes[k].amount) * s;
        end
        mag = (sum < 0) ? -sum : sum;
        mag = (mag + 20) / 40;
        if (sum < 0)
            mag = -mag;
        if (mag > FULL_SCALE)
            mag = FULL_SCALE;
        if (code >= CODE_POW_MIN)
        begin
            if (mag < 0)
                mag = 0;
        end
        else if (mag < -FULL_SCALE)
            mag = -FULL_SCALE;
        return 16'(mag);
    endfunction

    function automatic logic [7:0] mode_byte(logic [1:0] src, bit gate);
        return {5'b00000, src, gate};
    endfunction

    function automatic stim_row_t wr(logic [3:0] idx, logic [7:0] data);
        stim_row_t r;
        r = '{ROW_WRITE, idx, data, 8'd0, 7'd0, 7'd0, 1'b0, 0};
        return r;
    endfunction

    function automatic stim_row_t query(logic [7:0] code, logic [6:0] vel, logic [6:0] note);
        stim_row_t r;
        r = '{ROW_QUERY, 4'd0, 8'd0, code, vel, note, 1'b0, 0};
        return r;
    endfunction

    function automatic stim_row_t query_is(logic [7:0] code, logic [6:0] vel, logic [6:0] note,
                                           int fraction);
        stim_row_t r;
        r = '{ROW_QUERY, 4'd0, 8'd0, code, vel, note, 1'b1, fraction};
        return r;
    endfunction

    // mostly random, sometimes the domain ends or a step around the threshold
    function automatic logic [6:0] pick_level(logic [7:0] thr);
        int v;
        case ($urandom_range(9))
            0:       v = 0;
            1:       v = 127;
            2, 3:    v = int'(thr) + int'($urandom_range(4)) - 2;
            default: v = int'($urandom_range(127));
        endcase
        if (v < 0)
            v = 0;
        if (v > 127)
            v = 127;
        return 7'(v);
    endfunction

    function automatic void report(string what, int want, int got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected %0d, got %0d", what, want, got);
    endfunction

    task automatic write_reg(logic [3:0] idx, logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (!idx[3])
        begin
            case (idx[1:0])
                REG_TARGET: lanes[idx[2]].target    = data;
                REG_AMOUNT: lanes[idx[2]].amount    = data;
                REG_THRESH: lanes[idx[2]].threshold = data;
                default:    lanes[idx[2]].mode      = data[2:0];
            endcase
        end
    endtask

    task automatic quiesce();
        req.valid <= 1'b0;
        do
            @(posedge clk);
        while (fraction_due.size() != 0);
    endtask

    task automatic send(logic [7:0] code, logic [6:0] vel, logic [6:0] note, bit typed,
                        int fraction);
        while ($urandom_range(99) < send_idle)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.param_code <= code;
        req.velocity   <= vel;
        req.note       <= note;
        do
            @(posedge clk);
        while (!req.ready);
        fraction_due.push_back(typed ? 16'(fraction) : predict_fraction(code, vel, note));
    endtask

    task automatic reprogram_lanes();
        logic [7:0] target_v;
        logic [7:0] amount_v;
        logic [7:0] thresh_v;
        for (int k = 0; k < LANES; k++)
        begin
            target_v = ($urandom_range(9) == 0) ? 8'($urandom()) : 8'($urandom_range(7));
            case ($urandom_range(9))
                0:       amount_v = 8'h80;
                1:       amount_v = 8'h7F;
                2:       amount_v = 8'hFF;
                3:       amount_v = 8'h01;
                4:       amount_v = 8'h00;
                default: amount_v = 8'($urandom());
            endcase
            case ($urandom_range(9))
                0:       thresh_v = 8'd0;
                1:       thresh_v = 8'd255;
                2:       thresh_v = NOTE_LO;
                3:       thresh_v = NOTE_HI;
                4:       thresh_v = VEL_HI;
                default: thresh_v = 8'($urandom_range(140));
            endcase
            write_reg({1'b0, 1'(k), REG_TARGET}, target_v);
            write_reg({1'b0, 1'(k), REG_AMOUNT}, amount_v);
            write_reg({1'b0, 1'(k), REG_THRESH}, thresh_v);
            write_reg({1'b0, 1'(k), REG_MODE}, 8'($urandom()));
        end
        if ($urandom_range(3) == 0)
            write_reg({1'b1, 3'($urandom())}, 8'($urandom()));
    endtask

    task automatic random_query();
        logic [7:0] code;
        if ($urandom_range(99) < 75)
            code = lanes[$urandom_range(1)].target;
        else
            code = 8'($urandom());
        send(code, pick_level(lanes[$urandom_range(1)].threshold),
             pick_level(lanes[$urandom_range(1)].threshold), 1'b0, 0);
    endtask

    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (fraction_due.size() == 0)
                report("fraction with no request pending", 0, rsp.fraction);
            else if (rsp.fraction !== fraction_due[0])
                report("fraction", fraction_due.pop_front(), rsp.fraction);
            else
                void'(fraction_due.pop_front());
        end
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        req.valid      <= 1'b0;
        req.param_code <= '0;
        req.velocity   <= '0;
        req.note       <= '0;
        foreach (lanes[k])
            lanes[k] = '{8'd0, 8'sd0, 8'd0, 3'd0};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        script = {
            query_is(8'd0, 7'd0, 7'd0, 0),
            query_is(8'd255, 7'd127, 7'd127, 0),
            wr(A_TARGET, 8'd1), wr(A_AMOUNT, 8'h7F), wr(A_MODE, mode_byte(SRC_VEL_UP, 1'b1)),
            wr(B_TARGET, 8'd1), wr(B_AMOUNT, 8'h7F), wr(B_MODE, mode_byte(SRC_VEL_UP, 1'b1)),
            query_is(8'd1, 7'd127, 7'd0, FULL_SCALE),
            query_is(8'd1, 7'd0, 7'd127, FULL_SCALE),
            wr(A_AMOUNT, 8'h80), wr(B_AMOUNT, 8'h80),
            query_is(8'd1, 7'd64, 7'd64, -FULL_SCALE),
            wr(A_TARGET, 8'd5), wr(B_TARGET, 8'd5),
            query_is(8'd5, 7'd100, 7'd50, 0),
            wr(A_AMOUNT, 8'd1), wr(B_AMOUNT, 8'd0),
            query_is(8'd5, 7'd0, 7'd0, 1638),
            wr(A_THRESH, 8'd64), wr(A_MODE, mode_byte(SRC_VEL_UP, 1'b0)), wr(A_AMOUNT, 8'd9),
            query_is(8'd5, 7'd63, 7'd0, 0),
            query(8'd5, 7'd96, 7'd0),
            wr(A_TARGET, 8'd4),
            query(8'd4, 7'd96, 7'd0),
            query(8'd4, 7'd127, 7'd0),
            wr(A_MODE, mode_byte(SRC_VEL_DN, 1'b0)),
            query(8'd4, 7'd10, 7'd0),
            query_is(8'd4, 7'd70, 7'd0, 0),
            wr(A_THRESH, NOTE_HI), wr(A_MODE, mode_byte(SRC_NOTE_UP, 1'b0)),
            query(8'd4, 7'd0, 7'd120),
            wr(A_THRESH, 8'd0), wr(A_MODE, mode_byte(SRC_NOTE_DN, 1'b0)),
            query(8'd4, 7'd0, 7'd0),
            query_is(8'd4, 7'd0, 7'd5, 0),
            wr(A_AMOUNT, 8'hF7),
            query(8'd4, 7'd0, 7'd0),
            wr(A_MODE, 8'hF8 | mode_byte(SRC_VEL_UP, 1'b1)),
            query(8'd4, 7'd0, 7'd0),
            wr(IDX_UNMAPPED, 8'hFF),
            query(8'd4, 7'd0, 7'd0),
            wr(B_TARGET, 8'd0), wr(B_AMOUNT, 8'd3), wr(B_MODE, mode_byte(SRC_VEL_UP, 1'b1)),
            query(8'd0, 7'd50, 7'd60)
        };

        foreach (script[i])
        begin
            if (script[i].kind == ROW_WRITE)
            begin
                quiesce();
                write_reg(script[i].idx, script[i].data);
            end
            else
                send(script[i].code, script[i].vel, script[i].note, script[i].typed,
                     script[i].fraction);
        end

        // four idle patterns; lanes reprogrammed once the pipe has drained
        for (int blk = 0; blk < BLOCKS; blk++)
        begin
            case (blk / (BLOCKS / 4))
                0:
                begin
                    send_idle = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle = 78;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle = 0;
                    stall_pct = 78;
                end
                default:
                begin
                    send_idle = 29;
                    stall_pct = 29;
                end
            endcase
            quiesce();
            reprogram_lanes();
            repeat (BLOCK_LEN) random_query();
        end

        quiesce();
        repeat (PIPE_DEPTH + 4) @(posedge clk);
        mismatches += fraction_due.size();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
rtl/vnma_pkg.sv
rtl/vnma_if.sv
rtl/velocity_note_mod_amount.sv
rtl/vnma_checker.sv
verif/testbench.sv
